>>> rtl/pafm_pkg.sv
package pafm_pkg;

    // field widths
    localparam int PERIOD_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int FREQ_W      = 32;
    localparam int SCALE_W     = 32;
    localparam int LIMIT_W     = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // shared divider widths
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    // defaults
    localparam int                  SAMPLES_PER_MEAN_DEF = 4;
    localparam logic [SCALE_W-1:0]  CLOCK_SCALE_RST      = 32'd2250000000;
    localparam logic [LIMIT_W-1:0]  TIMEOUT_LIMIT_RST    = 16'd120;

    // operation codes
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_SCALE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NONE  = 2'd0,
        ST_LOW   = 2'd1,
        ST_HIGH  = 2'd2,
        ST_VALID = 2'd3
    } status_t;

    // divider launch and completion
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_stat_t;

endpackage

>>> rtl/pafm_in_if.sv
interface pafm_in_if;
    import pafm_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [PERIOD_W-1:0] period;
    logic                overcapture;
    logic                overrun;

    modport source (output valid, op, period, overcapture, overrun, input ready);
    modport sink   (input valid, op, period, overcapture, overrun, output ready);
endinterface

>>> rtl/pafm_out_if.sv
interface pafm_out_if;
    import pafm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FREQ_W-1:0]   frequency;

    modport source (output valid, status, frequency, input ready);
    modport sink   (input valid, status, frequency, output ready);
endinterface

>>> rtl/pafm_div.sv
module pafm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pafm_pkg::div_ctrl_t ctrl,
    output pafm_pkg::div_stat_t stat
);
    import pafm_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;
    logic [DIVISOR_W-1:0]  rem_next;

    // one restoring step: bring down a dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            quo_reg <= ctrl.dividend;
            dvs_reg <= ctrl.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

>>> rtl/period_average_frequency_meter.sv
// capture item: handled on its transfer; one that completes a group takes the
// mean in SEQ_MEAN by a reciprocal multiply, then divides the scale by it on the
// shared 32-step divider; the input is held off until the sequencer is idle again
// tick item: result registered in the cycle after; next item waits only on report.ready
// reset: asynchronous, active low; clears the sequencer, counters and flags,
// loads the register defaults and holds too low, not fresh, until the first update
module period_average_frequency_meter #(
    parameter int SAMPLES_PER_MEAN = pafm_pkg::SAMPLES_PER_MEAN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pafm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pafm_pkg::CFG_DATA_W-1:0]      cfg_data,
    pafm_in_if.sink                              meas,
    pafm_out_if.source                           report
);
    import pafm_pkg::*;

    localparam int CNT_W = (SAMPLES_PER_MEAN > 1) ? $clog2(SAMPLES_PER_MEAN) : 1;
    localparam int SUM_W = PERIOD_W + CNT_W;
    localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(SAMPLES_PER_MEAN - 1);

    // rounded-up reciprocal of the group size, exact for every sum that fits SUM_W
    localparam int MEAN_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W    = MEAN_SHIFT + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(((64'd1 << MEAN_SHIFT)
        + 64'(SAMPLES_PER_MEAN) - 64'd1) / 64'(SAMPLES_PER_MEAN));

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_MEAN = 3'b010,
        SEQ_FREQ = 3'b100
    } seq_t;

    seq_t               state_reg, state_next;
    logic [SCALE_W-1:0] clock_scale_reg;
    logic [LIMIT_W-1:0] timeout_limit_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LIMIT_W-1:0] idle_reg, idle_next;
    status_t            held_status_reg, held_status_next;
    logic [FREQ_W-1:0]  held_freq_reg, held_freq_next;
    logic               fresh_reg, fresh_next;
    logic               out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FREQ_W-1:0]  out_freq_reg, out_freq_next;

    logic               in_xfer;
    logic               out_xfer;
    logic [SUM_W-1:0]   sum_new;
    logic [LIMIT_W-1:0] idle_inc;
    logic [PROD_W-1:0]  mean_prod;
    logic [DIVISOR_W-1:0] mean;
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;

    // shared divider
    pafm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    // handshakes
    assign meas.ready    = (state_reg == SEQ_IDLE) && (!out_valid_reg || report.ready);
    assign in_xfer       = meas.valid && meas.ready;
    assign out_xfer      = out_valid_reg && report.ready;
    assign report.valid  = out_valid_reg;
    assign report.status = out_status_reg;
    assign report.frequency = out_freq_reg;

    // running sum, restarted at the first sample of a group
    assign sum_new  = ((count_reg == '0) ? '0 : sum_reg) + SUM_W'(meas.period);
    assign idle_inc = idle_reg + LIMIT_W'(1);

    // group mean by reciprocal multiply of the registered sum
    assign mean_prod = PROD_W'(sum_reg) * PROD_W'(MEAN_RECIP);
    assign mean      = mean_prod[MEAN_SHIFT +: DIVISOR_W];

    // sequencer and item handling
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        idle_next        = idle_reg;
        held_status_next = held_status_reg;
        held_freq_next   = held_freq_reg;
        fresh_next       = fresh_reg;
        out_valid_next   = out_xfer ? 1'b0 : out_valid_reg;
        out_status_next  = out_status_reg;
        out_freq_next    = out_freq_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = DIVIDEND_W'(clock_scale_reg);
        div_ctrl.divisor  = mean;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_xfer && (meas.op == OP_CAPTURE))
                begin
                    idle_next = '0;
                    if (meas.overcapture)
                    begin
                        count_next       = '0;
                        held_status_next = ST_HIGH;
                        held_freq_next   = '0;
                        fresh_next       = 1'b1;
                    end
                    else if (meas.overrun)
                    begin
                        count_next       = '0;
                        held_status_next = ST_LOW;
                        held_freq_next   = '0;
                        fresh_next       = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_new;
                        if (count_reg == LAST_SAMPLE)
                        begin
                            count_next = '0;
                            state_next = SEQ_MEAN;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else if (in_xfer)
                begin
                    out_valid_next = 1'b1;
                    if (idle_inc >= timeout_limit_reg)
                    begin
                        idle_next        = '0;
                        held_status_next = ST_LOW;
                        held_freq_next   = '0;
                        out_status_next  = ST_LOW;
                        out_freq_next    = '0;
                    end
                    else if (!fresh_reg)
                    begin
                        idle_next       = idle_inc;
                        out_status_next = ST_NONE;
                        out_freq_next   = '0;
                    end
                    else
                    begin
                        idle_next       = idle_inc;
                        fresh_next      = 1'b0;
                        out_status_next = held_status_reg;
                        out_freq_next   = (held_status_reg == ST_VALID) ? held_freq_reg : '0;
                    end
                end
            end
            SEQ_MEAN:
            begin
                // zero mean reads as too high, otherwise divide the scale by it
                if (mean == '0)
                begin
                    held_status_next = ST_HIGH;
                    held_freq_next   = '0;
                    fresh_next       = 1'b1;
                    state_next       = SEQ_IDLE;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = SEQ_FREQ;
                end
            end
            SEQ_FREQ:
            begin
                if (div_stat.done)
                begin
                    held_status_next = ST_VALID;
                    held_freq_next   = FREQ_W'(div_stat.quotient);
                    fresh_next       = 1'b1;
                    state_next       = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            count_reg       <= '0;
            idle_reg        <= '0;
            held_status_reg <= ST_LOW;
            held_freq_reg   <= '0;
            fresh_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            idle_reg        <= idle_next;
            held_status_reg <= held_status_next;
            held_freq_reg   <= held_freq_next;
            fresh_reg       <= fresh_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        out_status_reg <= out_status_next;
        out_freq_reg   <= out_freq_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_scale_reg   <= CLOCK_SCALE_RST;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLOCK_SCALE:   clock_scale_reg   <= SCALE_W'(cfg_data);
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:           clock_scale_reg   <= clock_scale_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg != SEQ_IDLE))
        else $error("divider completion outside a division");

    // a tick transfer always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (meas.op == OP_TICK)) |=> report.valid)
        else $error("tick produced no result");

    // a capture never creates a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (meas.op == OP_CAPTURE) && !report.valid) |=> !report.valid)
        else $error("capture produced a result");

    // the fresh flag only clears on a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(fresh_reg) |-> $past(in_xfer && (meas.op == OP_TICK)))
        else $error("fresh flag cleared without a tick");

    // sample counter stays within one group
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_SAMPLE)
        else $error("sample counter out of range");
`endif

endmodule

>>> tb/sv/tb_period_average_frequency_meter.sv
`timescale 1ns / 100ps

module tb_period_average_frequency_meter;
    import pafm_pkg::*;

    localparam int GROUP          = SAMPLES_PER_MEAN_DEF;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_ITEMS    = 290;
    localparam int NUM_PHASES     = 6;
    localparam int DIRECTED_ROWS  = 25;

    typedef struct packed {
        logic                op;
        logic [PERIOD_W-1:0] period;
        logic                overcapture;
        logic                overrun;
    } meas_item_t;

    typedef struct packed {
        status_t           status;
        logic [FREQ_W-1:0] frequency;
    } reading_t;

    // one directed row: the item and, where obvious, the reading it must give
    typedef struct packed {
        meas_item_t item;
        logic       typed;
        reading_t   reading;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // first tick after reset: nothing fresh yet
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_NONE,  32'd0}},
        // slowest input: four full-scale periods
        '{'{OP_CAPTURE, 16'hFFFF,  1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'hFFFF,  1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'hFFFF,  1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'hFFFF,  1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_VALID, 32'd34332}},
        // result counts as read
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_NONE,  32'd0}},
        // missed capture
        '{'{OP_CAPTURE, 16'd0,     1'b1, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_HIGH,  32'd0}},
        // both flags: overcapture wins
        '{'{OP_CAPTURE, 16'h1234,  1'b1, 1'b1}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_HIGH,  32'd0}},
        // timer overrun
        '{'{OP_CAPTURE, 16'hFFFF,  1'b0, 1'b1}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_LOW,   32'd0}},
        // mean rounds down to zero
        '{'{OP_CAPTURE, 16'd0,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'd0,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'd0,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'd3,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_HIGH,  32'd0}},
        // fastest input: mean of one clock
        '{'{OP_CAPTURE, 16'd1,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'd1,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'd1,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_CAPTURE, 16'd1,     1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_VALID, 32'd2250000000}},
        // partial group gives nothing new
        '{'{OP_CAPTURE, 16'h5A5A,  1'b0, 1'b0}, 1'b0, '{ST_NONE,  32'd0}},
        '{'{OP_TICK,    16'd0,     1'b0, 1'b0}, 1'b1, '{ST_NONE,  32'd0}}
    };

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pafm_in_if  meas_ch ();
    pafm_out_if report_ch ();

    period_average_frequency_meter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_ch),
        .report    (report_ch)
    );

    // meter copy: registers and state
    logic [SCALE_W-1:0]  scale_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [PERIOD_W-1:0] period_hist [GROUP];
    int unsigned         hist_fill;
    logic [LIMIT_W-1:0]  quiet_ticks;
    status_t             held_status;
    logic [FREQ_W-1:0]   held_freq;
    bit                  fresh;

    reading_t expected_readings [$];
    int       mismatch_count;
    bit       calm;
    int       phase_sent;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10000000;
        $display("tb_period_average_frequency_meter: errors");
        $finish;
    end

    // advance the meter copy by one item; returns 1 when a reading is due
    function automatic bit meter_predict(input meas_item_t it, output reading_t r);
        logic [PERIOD_W+1:0] sum;
        logic [PERIOD_W-1:0] mean;
        r = '{ST_NONE, '0};
        if (it.op == OP_CAPTURE)
        begin
            quiet_ticks = '0;
            if (it.overcapture)
            begin
                hist_fill   = 0;
                held_status = ST_HIGH;
                held_freq   = '0;
                fresh       = 1'b1;
            end
            else if (it.overrun)
            begin
                hist_fill   = 0;
                held_status = ST_LOW;
                held_freq   = '0;
                fresh       = 1'b1;
            end
            else
            begin
                period_hist[hist_fill] = it.period;
                hist_fill++;
                if (hist_fill == GROUP)
                begin
                    hist_fill = 0;
                    sum = '0;
                    for (int i = 0; i < GROUP; i++)
                        sum += period_hist[i];
                    mean  = PERIOD_W'(sum / GROUP);
                    fresh = 1'b1;
                    if (mean == '0)
                    begin
                        held_status = ST_HIGH;
                        held_freq   = '0;
                    end
                    else
                    begin
                        held_status = ST_VALID;
                        held_freq   = scale_reg / {16'd0, mean};
                    end
                end
            end
            return 1'b0;
        end
        // tick: timeout first, then one-shot report of the held result
        quiet_ticks = quiet_ticks + 1'b1;
        if (quiet_ticks >= limit_reg)
        begin
            quiet_ticks = '0;
            held_status = ST_LOW;
            held_freq   = '0;
            r = '{ST_LOW, '0};
        end
        else if (fresh)
        begin
            r.status    = held_status;
            r.frequency = (held_status == ST_VALID) ? held_freq : '0;
            fresh       = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic meas_item_t capture_item(input logic [PERIOD_W-1:0] p,
                                                input logic oc, input logic ovr);
        return '{OP_CAPTURE, p, oc, ovr};
    endfunction

    function automatic meas_item_t tick_item();
        return '{OP_TICK, PERIOD_W'($urandom), 1'($urandom), 1'($urandom)};
    endfunction

    // periods from several ranges so that small, large and zero means all occur
    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 3))
            0: return PERIOD_W'($urandom);
            1: return PERIOD_W'($urandom_range(0, 15));
            2: return 16'hFFFF - PERIOD_W'($urandom_range(0, 255));
            default: return PERIOD_W'($urandom_range(100, 5000));
        endcase
    endfunction

    // one input transfer, then any expected reading is queued
    task automatic send_item(input meas_item_t it, input bit typed = 1'b0,
                             input reading_t typed_reading = '0);
        reading_t r;
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            meas_ch.valid <= 1'b0;
            @(posedge clk);
        end
        meas_ch.valid       <= 1'b1;
        meas_ch.op          <= it.op;
        meas_ch.period      <= it.period;
        meas_ch.overcapture <= it.overcapture;
        meas_ch.overrun     <= it.overrun;
        do
            @(posedge clk);
        while (!meas_ch.ready);
        phase_sent++;
        if (meter_predict(it, r))
            expected_readings.push_back(typed ? typed_reading : r);
    endtask

    // hold the input until every expected reading has come back
    task automatic drain_readings();
        meas_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // idle the block fully, including a division still under way
    task automatic settle();
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [SCALE_W-1:0] scale,
                                input logic [LIMIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLOCK_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT_LIMIT;
        cfg_data  <= {16'd0, limit};
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        scale_reg = scale;
        limit_reg = limit;
    endtask

    // one random burst: mostly complete groups, some broken ones and noise
    task automatic random_burst();
        int kind;
        int n;
        logic [1:0] flags;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            repeat (GROUP) send_item(capture_item(pick_period(), 1'b0, 1'b0));
            n = $urandom_range(1, 3);
            repeat (n) send_item(tick_item());
        end
        else if (kind < 65)
        begin
            n = $urandom_range(0, GROUP - 1);
            repeat (n) send_item(capture_item(pick_period(), 1'b0, 1'b0));
            flags = 2'($urandom_range(1, 3));
            send_item(capture_item(pick_period(), flags[0], flags[1]));
            send_item(tick_item());
        end
        else if (kind < 80)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(tick_item());
        end
        else if (kind < 82)
        begin
            // long quiet stretch to run into the timeout when the limit is small
            n = (limit_reg <= 130) ? int'(limit_reg) + 2 : 10;
            repeat (n) send_item(tick_item());
        end
        else if (kind < 84)
            drain_readings();
        else
            send_item('{1'($urandom), PERIOD_W'($urandom),
                        1'($urandom_range(0, 99) < 8), 1'($urandom_range(0, 99) < 8)});
    endtask

    // result side: random stalls, compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected reading: status %0d frequency %0d",
                       report_ch.status, report_ch.frequency);
                mismatch_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (report_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, report_ch.status);
                    mismatch_count++;
                end
                if (report_ch.frequency !== want.frequency)
                begin
                    $error("frequency: expected %0d, actual %0d",
                           want.frequency, report_ch.frequency);
                    mismatch_count++;
                end
            end
        end
        report_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // stimulus
    initial
    begin
        logic [SCALE_W-1:0] phase_scale [NUM_PHASES];
        logic [LIMIT_W-1:0] phase_limit [NUM_PHASES];

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_CLOCK_SCALE;
        cfg_data            <= '0;
        meas_ch.valid       <= 1'b0;
        meas_ch.op          <= OP_TICK;
        meas_ch.period      <= '0;
        meas_ch.overcapture <= 1'b0;
        meas_ch.overrun     <= 1'b0;

        mismatch_count = 0;
        calm           = 1'b0;
        phase_sent     = 0;
        scale_reg      = CLOCK_SCALE_RST;
        limit_reg      = TIMEOUT_LIMIT_RST;
        hist_fill      = 0;
        quiet_ticks    = '0;
        held_status    = ST_LOW;
        held_freq      = '0;
        fresh          = 1'b0;

        // defaults, minimum, maximum, zero corners, random, back to defaults
        phase_scale[0] = CLOCK_SCALE_RST;  phase_limit[0] = TIMEOUT_LIMIT_RST;
        phase_scale[1] = 32'd1;            phase_limit[1] = 16'd1;
        phase_scale[2] = 32'hFFFF_FFFF;    phase_limit[2] = 16'hFFFF;
        phase_scale[3] = 32'd0;            phase_limit[3] = 16'd0;
        phase_scale[4] = SCALE_W'($urandom);
        phase_limit[4] = LIMIT_W'($urandom_range(2, 40));
        phase_scale[5] = CLOCK_SCALE_RST;  phase_limit[5] = TIMEOUT_LIMIT_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table on reset defaults
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].reading);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                settle();
                write_config(phase_scale[ph], phase_limit[ph]);
            end
            // one phase runs with no idling on either side
            calm       = (ph == 2);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
                random_burst();
        end
        calm = 1'b0;

        settle();
        if (mismatch_count == 0)
            $display("tb_period_average_frequency_meter: clean");
        else
            $display("tb_period_average_frequency_meter: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/pafm_pkg.sv
rtl/pafm_in_if.sv
rtl/pafm_out_if.sv
rtl/pafm_div.sv
rtl/period_average_frequency_meter.sv
tb/sv/tb_period_average_frequency_meter.sv
